>>> rtl/date_string_to_seconds_assert.svh
// Assertion macros for the date string converter checker.
// Needs a signal named clk and an active-low reset arst_n in the using scope.
`ifndef DATE_STRING_TO_SECONDS_ASSERT_SVH
`define DATE_STRING_TO_SECONDS_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define DSTS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsts: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define DSTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsts: next-cycle check failed");

`endif

>>> rtl/dsts_pkg.sv
// Shared types, constants and lookup functions for the date string converter.
// No dependencies.
package dsts_pkg;

	localparam logic [7:0]  MAX_CHARS    = 8'd63;
	localparam logic [31:0] INVALID_CODE = 32'hFFFF_FFFE;
	localparam logic [31:0] SIGN_FLIP    = 32'h8000_0000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam logic [15:0] CENTURY    = 16'd1900;
	localparam logic [15:0] TWO_DIGIT  = 16'd100;
	localparam logic [15:0] YEAR_MIN   = 16'd1970;
	localparam logic [15:0] YEAR_MAX   = 16'd2050;
	localparam logic [15:0] YEAR_EPOCH = 16'd1901;

	localparam logic [1:0] TOK_DAY   = 2'd0;
	localparam logic [1:0] TOK_MONTH = 2'd1;
	localparam logic [1:0] TOK_YEAR  = 2'd2;
	localparam logic [1:0] TOK_EXTRA = 2'd3;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic feed;   // accepted byte goes into the scanner
		logic ev1;    // capture checks, clear scanner
		logic ev2;    // day count
		logic ev3;    // hours
		logic load;   // seconds into the output register
	} dp_cmd_t;

	// Upper-case three-letter name (first letter in low byte) to month 1..12, 0 if none
	function automatic logic [3:0] month_lookup(input logic [23:0] name);
		logic [3:0] m;
		case (name)
			24'h4E414A: m = 4'd1;
			24'h424546: m = 4'd2;
			24'h52414D: m = 4'd3;
			24'h525041: m = 4'd4;
			24'h59414D: m = 4'd5;
			24'h4E554A: m = 4'd6;
			24'h4C554A: m = 4'd7;
			24'h475541: m = 4'd8;
			24'h504553: m = 4'd9;
			24'h54434F: m = 4'd10;
			24'h564F4E: m = 4'd11;
			24'h434544: m = 4'd12;
			default:    m = 4'd0;
		endcase
		return m;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

>>> rtl/dsts_if.sv
// Valid/ready channel interfaces: one for string bytes, one for results.
// Depends on nothing.
interface dsts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
	modport monitor (input valid, ready, ch, last);
endinterface

interface dsts_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds;
	logic        invalid;

	modport source (output valid, seconds, invalid, input ready);
	modport sink (input valid, seconds, invalid, output ready);
	modport monitor (input valid, ready, seconds, invalid);
endinterface

>>> rtl/dsts_ctrl.sv
// Controller: sequences scanning and the four evaluation steps, owns output valid.
// Depends on dsts_pkg.
module dsts_ctrl import dsts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_SCAN,
		ST_EV1,
		ST_EV2,
		ST_EV3,
		ST_EV4
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   load;

	assign in_ready = (state_q == ST_SCAN);
	assign accept   = in_valid && in_ready;
	// result register free, or being emptied this cycle
	assign load     = (state_q == ST_EV4) && (!out_valid_q || out_ready);

	assign cmd.feed = accept;
	assign cmd.ev1  = (state_q == ST_EV1);
	assign cmd.ev2  = (state_q == ST_EV2);
	assign cmd.ev3  = (state_q == ST_EV3);
	assign cmd.load = load;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SCAN: begin
					if (accept && in_last) begin
						state_q <= ST_EV1;
					end
				end
				ST_EV1: state_q <= ST_EV2;
				ST_EV2: state_q <= ST_EV3;
				ST_EV3: state_q <= ST_EV4;
				ST_EV4: begin
					if (load) begin
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_SCAN;
			endcase
		end
	end

endmodule

>>> rtl/dsts_dp.sv
// Datapath: byte scanner with token accumulators, then a four-step evaluation
// pipeline ending in the result register. Depends on dsts_pkg.
module dsts_dp import dsts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  ch,
	output logic [31:0] seconds,
	output logic        invalid
);

	function automatic logic [15:0] acc10(input logic [15:0] a, input logic [3:0] d);
		logic [19:0] v;
		v = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {16'd0, d};
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	// scanner state
	logic [7:0]  count_q;
	logic [1:0]  tok_q;
	logic        in_token_q;
	logic        ended_q;
	logic [15:0] day_q, mon_q, year_q;
	logic        day_dig_q, mon_dig_q, year_dig_q;
	logic [7:0]  mon_let_q [0:2];
	logic [1:0]  mon_len_q;

	logic        is_digit, is_sep;
	logic [3:0]  digit;
	logic [7:0]  upper;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
	assign is_sep   = (ch == CH_SPACE) || (ch == CH_DASH);
	assign upper    = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) ? (ch - CASE_GAP) : ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			tok_q      <= TOK_DAY;
			in_token_q <= 1'b0;
			ended_q    <= 1'b0;
			day_q      <= '0;
			mon_q      <= '0;
			year_q     <= '0;
			day_dig_q  <= 1'b1;
			mon_dig_q  <= 1'b1;
			year_dig_q <= 1'b1;
			mon_let_q  <= '{default: 8'd0};
			mon_len_q  <= '0;
		end else if (cmd.ev1) begin
			count_q    <= '0;
			tok_q      <= TOK_DAY;
			in_token_q <= 1'b0;
			ended_q    <= 1'b0;
			day_q      <= '0;
			mon_q      <= '0;
			year_q     <= '0;
			day_dig_q  <= 1'b1;
			mon_dig_q  <= 1'b1;
			year_dig_q <= 1'b1;
			mon_let_q  <= '{default: 8'd0};
			mon_len_q  <= '0;
		end else if (cmd.feed && !ended_q) begin
			if (ch == CH_NUL) begin
				ended_q <= 1'b1;
			end else begin
				if (count_q != 8'hFF) begin
					count_q <= count_q + 8'd1;
				end
				if (is_sep) begin
					if (in_token_q) begin
						in_token_q <= 1'b0;
						if (tok_q != TOK_EXTRA) begin
							tok_q <= tok_q + 2'd1;
						end
					end
				end else begin
					in_token_q <= 1'b1;
					case (tok_q)
						TOK_DAY: begin
							if (is_digit) day_q <= acc10(day_q, digit);
							else day_dig_q <= 1'b0;
						end
						TOK_MONTH: begin
							if (is_digit) mon_q <= acc10(mon_q, digit);
							else mon_dig_q <= 1'b0;
							if (mon_len_q != 2'd3) begin
								mon_let_q[mon_len_q] <= upper;
								mon_len_q <= mon_len_q + 2'd1;
							end
						end
						TOK_YEAR: begin
							if (is_digit) year_q <= acc10(year_q, digit);
							else year_dig_q <= 1'b0;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// step 1: validation and month decode
	logic [15:0] year_adj;
	logic [3:0]  mnum;
	logic        mon_ok, year_ok, day_ok, leap, tok_ok, ok;
	logic [4:0]  maxday;

	always_comb begin
		tok_ok   = (tok_q == TOK_EXTRA) || ((tok_q == TOK_YEAR) && in_token_q);
		year_adj = (year_q <= TWO_DIGIT) ? (year_q + CENTURY) : year_q;
		year_ok  = year_dig_q && (year_adj >= YEAR_MIN) && (year_adj <= YEAR_MAX);
		if (mon_dig_q) begin
			mnum   = mon_q[3:0];
			mon_ok = (mon_q >= 16'd1) && (mon_q <= 16'(MON_DEC));
		end else begin
			mnum   = month_lookup({mon_let_q[2], mon_let_q[1], mon_let_q[0]});
			mon_ok = (mon_len_q == 2'd3) && (mnum != 4'd0);
		end
		// within 1970..2050 only 2000 is a century year, and it is a leap year
		leap   = (year_adj[1:0] == 2'd0);
		maxday = month_days(mnum) + 5'((mnum == MON_FEB) && leap);
		day_ok = day_dig_q && (day_q >= 16'd1) && (day_q <= 16'(maxday));
		ok     = tok_ok && (count_q < MAX_CHARS) && year_ok && mon_ok && day_ok;
	end

	logic        ok_s1, leap_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [7:0]  y_s1;
	logic        ok_s2;
	logic [15:0] days_s2;
	logic        ok_s3;
	logic [20:0] hours_s3;
	logic [32:0] prod;
	logic [31:0] seconds_q;
	logic        invalid_q;

	logic [15:0] y_full;
	assign y_full = year_adj - YEAR_EPOCH;

	always_ff @(posedge clk) begin
		if (cmd.ev1) begin
			ok_s1    <= ok;
			leap_s1  <= leap;
			month_s1 <= mnum;
			day_s1   <= day_q[4:0];
			y_s1     <= y_full[7:0];
		end
		if (cmd.ev2) begin
			ok_s2   <= ok_s1;
			days_s2 <= 16'(days_before(month_s1)) + 16'(day_s1) - 16'd1
				+ 16'(y_s1) * 16'd365 + 16'(y_s1 >> 2)
				+ 16'((month_s1 > MON_FEB) && leap_s1);
		end
		if (cmd.ev3) begin
			ok_s3    <= ok_s2;
			hours_s3 <= 21'(days_s2) * 21'd24 + 21'd7;
		end
		if (cmd.load) begin
			seconds_q <= ok_s3 ? (prod[31:0] ^ SIGN_FLIP) : INVALID_CODE;
			invalid_q <= !ok_s3;
		end
	end

	assign prod    = 33'(hours_s3) * 33'd3600;
	assign seconds = seconds_q;
	assign invalid = invalid_q;

endmodule

>>> rtl/date_string_to_seconds.sv
// Timing: a result is shown at the end of evaluation after the byte with last set,
// later only while an earlier result still waits in the result register.
// Throughput: one byte per cycle while scanning; after a last byte, the evaluation
// steps (checks, day count, hours, seconds multiply) run with input not ready.
// The result register lets the next string be scanned while a result waits.
// Reset (arst_n low, asynchronous): scanner cleared, no result pending.
module date_string_to_seconds import dsts_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	dsts_in_if.sink     chars,
	dsts_out_if.source  result
);

	// Command bundle from the controller to the datapath
	dp_cmd_t cmd;

	// Controller: accepts bytes in the scan state, steps through evaluation,
	// then holds the result valid until its transfer.
	dsts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_last   (chars.last),
		.in_ready  (chars.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Datapath: token accumulators, validation and seconds arithmetic.
	// Scanner clears on the first evaluation step, so a new string can follow.
	dsts_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.ch      (chars.ch),
		.seconds (result.seconds),
		.invalid (result.invalid)
	);

endmodule

>>> rtl/dsts_checker.sv
// Port-level checks for the date string converter, bound to the top level.
// Depends on dsts_pkg and date_string_to_seconds_assert.svh.
`include "date_string_to_seconds_assert.svh"

module dsts_checker import dsts_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        chars_valid,
	input logic        chars_ready,
	input logic        chars_last,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_seconds,
	input logic        result_invalid
);

	logic last_xfer;
	assign last_xfer = chars_valid && chars_ready && chars_last;

	// a held result stays offered
	`DSTS_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid)
	// invalid results carry the fixed code
	`DSTS_ASSERT_SAME(a_inv_code, result_valid && result_invalid, result_seconds == INVALID_CODE)
	// evaluation blocks the input
	`DSTS_ASSERT_NEXT(a_eval_busy, last_xfer, !chars_ready)
	// an unobstructed result appears a fixed time after its last byte
	`DSTS_ASSERT_SAME(a_latency, $rose(result_valid), $past(last_xfer, 5))

endmodule

bind date_string_to_seconds dsts_checker u_dsts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.chars_valid    (chars.valid),
	.chars_ready    (chars.ready),
	.chars_last     (chars.last),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_seconds (result.seconds),
	.result_invalid (result.invalid)
);

>>> tb/date_string_to_seconds_tb.sv
// Self-checking testbench for date_string_to_seconds: date strings are sent one byte per
// transfer and every result is checked against a predictor kept inside this module.
// Depends on rtl/dsts_pkg.sv, rtl/dsts_if.sv and rtl/date_string_to_seconds.sv.
module date_string_to_seconds_tb;
	import dsts_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [31:0] seconds;
		logic        invalid;
	} date_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsts_in_if chars_if ();
	dsts_out_if result_if ();

	date_string_to_seconds dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.result (result_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Calendar tables: lower-case names, and month lengths outside leap years
	string cal_name [12] = '{"january", "february", "march", "april", "may", "june",
		"july", "august", "september", "october", "november", "december"};
	int unsigned mon_span [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Predictor's copy of the scanner
	logic [7:0]  n_chars;
	logic [1:0]  tok;
	logic        tok_open, str_done;
	logic [15:0] day_acc, mon_acc, yr_acc;
	logic        day_num, mon_num, yr_num;
	logic [7:0]  mon_chr [3];
	logic [1:0]  mon_len;

	date_result_t pending_dates [$];
	date_result_t want_res;
	logic [7:0]   text [$];

	int unsigned send_idle_pct = 0;
	int unsigned take_idle_pct = 0;
	int unsigned sent_chars = 0;
	int unsigned fault_count = 0;
	int unsigned cycles = 0;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_scan();
		n_chars = '0;
		tok = TOK_DAY;
		tok_open = 1'b0;
		str_done = 1'b0;
		day_acc = '0;
		mon_acc = '0;
		yr_acc = '0;
		day_num = 1'b1;
		mon_num = 1'b1;
		yr_num = 1'b1;
		mon_chr = '{8'h00, 8'h00, 8'h00};
		mon_len = '0;
	endfunction

	function automatic bit is_leap(int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// decimal accumulators stick at the top of their 16-bit range
	function automatic logic [15:0] add_digit(logic [15:0] acc, logic [7:0] c);
		int unsigned v;
		v = 32'(acc) * 10 + 32'(c - CH_ZERO);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic bit date_to_seconds(output logic [31:0] secs);
		int unsigned yr, mo, top, y, days;
		mo = 0;
		secs = '0;
		// year token must at least have been opened
		if (!(tok == TOK_EXTRA || (tok == TOK_YEAR && tok_open)))
			return 1'b0;
		if (n_chars >= MAX_CHARS)
			return 1'b0;
		if (!yr_num)
			return 1'b0;
		yr = yr_acc;
		if (yr <= TWO_DIGIT)
			yr += CENTURY;
		if (yr < YEAR_MIN || yr > YEAR_MAX)
			return 1'b0;
		if (mon_num) begin
			if (mon_acc < 1 || mon_acc > 12)
				return 1'b0;
			mo = mon_acc;
		end else begin
			if (mon_len != 2'd3)
				return 1'b0;
			for (int m = 1; m <= 12 && mo == 0; m++)
				if (mon_chr[0] == cal_name[m-1][0] - CASE_GAP &&
				    mon_chr[1] == cal_name[m-1][1] - CASE_GAP &&
				    mon_chr[2] == cal_name[m-1][2] - CASE_GAP)
					mo = m;
			if (mo == 0)
				return 1'b0;
		end
		top = mon_span[mo];
		if (mo == 2 && is_leap(yr))
			top++;
		if (!day_num || day_acc < 1 || day_acc > top)
			return 1'b0;
		y = yr - YEAR_EPOCH;
		days = day_acc - 1 + 365 * y + y / 4;
		for (int k = 1; k < mo; k++)
			days += mon_span[k];
		if (mo > 2 && y % 4 == 3)
			days++;
		// wraps modulo 2**32 on purpose
		secs = ((24 * days + 7) * 3600) ^ SIGN_FLIP;
		return 1'b1;
	endfunction

	function automatic void scan_char(logic [7:0] c, logic fin);
		logic [31:0] secs;
		logic [7:0]  uc;
		bit          ok;
		date_result_t r;
		if (!str_done) begin
			if (c == CH_NUL) begin
				str_done = 1'b1;
			end else begin
				if (n_chars != 8'hFF)
					n_chars++;
				if (c == CH_SPACE || c == CH_DASH) begin
					if (tok_open) begin
						tok_open = 1'b0;
						if (tok != TOK_EXTRA)
							tok++;
					end
				end else begin
					tok_open = 1'b1;
					case (tok)
						TOK_DAY: begin
							if (c >= CH_ZERO && c <= CH_NINE) day_acc = add_digit(day_acc, c);
							else day_num = 1'b0;
						end
						TOK_MONTH: begin
							if (c >= CH_ZERO && c <= CH_NINE) mon_acc = add_digit(mon_acc, c);
							else mon_num = 1'b0;
							if (mon_len != 2'd3) begin
								uc = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
								mon_chr[mon_len] = uc;
								mon_len++;
							end
						end
						TOK_YEAR: begin
							if (c >= CH_ZERO && c <= CH_NINE) yr_acc = add_digit(yr_acc, c);
							else yr_num = 1'b0;
						end
						default: ;
					endcase
				end
			end
		end
		if (fin) begin
			ok = date_to_seconds(secs);
			r.seconds = ok ? secs : INVALID_CODE;
			r.invalid = !ok;
			pending_dates.push_back(r);
			clear_scan();
		end
	endfunction

	// ---------------------------------------------------------------- byte source

	// Data changes only at the falling edge; valid is left high when the next
	// byte follows straight away.
	task automatic send_char(logic [7:0] c, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			chars_if.valid <= 1'b0;
		end
		@(negedge clk);
		chars_if.valid <= 1'b1;
		chars_if.ch <= c;
		chars_if.last <= fin;
		do @(posedge clk); while (!chars_if.ready);
		scan_char(c, fin);
		sent_chars++;
	endtask

	task automatic send_text();
		int n;
		n = text.size();
		for (int i = 0; i < n; i++)
			send_char(text[i], i == n - 1);
		text.delete();
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	task automatic send_string(string s);
		put_text(s);
		send_text();
	endtask

	function automatic void put_gap();
		repeat ($urandom_range(1, 3))
			text.push_back($urandom_range(1) ? CH_DASH : CH_SPACE);
	endfunction

	// occasional leading zero, which must not change the value
	function automatic void put_number(int unsigned v);
		if ($urandom_range(9) == 0)
			text.push_back(CH_ZERO);
		put_text($sformatf("%0d", v));
	endfunction

	function automatic void put_word(string w, int n);
		logic [7:0] c;
		for (int i = 0; i < n && i < w.len(); i++) begin
			c = w[i];
			if ($urandom_range(1))
				c = c - CASE_GAP;
			text.push_back(c);
		end
	endfunction

	// Mostly well-formed dates with random content; some broken, some pure noise
	function automatic void build_date_text();
		int unsigned yr, mo, dy, top, pick;
		pick = $urandom_range(99);
		if (pick >= 90) begin
			repeat ($urandom_range(1, 24))
				text.push_back(8'($urandom_range(0, 255)));
		end else begin
			yr = ($urandom_range(9) == 0) ? $urandom_range(1940, 2080) : $urandom_range(1970, 2050);
			mo = $urandom_range(1, 12);
			top = mon_span[mo] + ((mo == 2 && is_leap(yr)) ? 1 : 0);
			dy = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, top);
			if ($urandom_range(4) == 0)
				put_gap();
			put_number(dy);
			put_gap();
			case ($urandom_range(5))
				0, 1, 2: put_number(($urandom_range(9) == 0) ? $urandom_range(0, 20) : mo);
				3, 4:    put_word(cal_name[mo-1], 3);
				default: put_word(cal_name[mo-1], $urandom_range(1) ? 9 : 2);
			endcase
			put_gap();
			if ($urandom_range(19) == 0)
				repeat ($urandom_range(40, 70)) text.push_back(CH_SPACE);
			if ($urandom_range(2) == 0 && yr <= 2000)
				put_number(yr - CENTURY);
			else
				put_number(yr);
			if ($urandom_range(6) == 0) begin
				put_gap();
				if ($urandom_range(1)) put_number($urandom_range(0, 9999));
				else put_word(cal_name[$urandom_range(0, 11)], 4);
			end
			if ($urandom_range(7) == 0)
				put_gap();
			if (pick >= 80) begin
				case ($urandom_range(2))
					0: text.delete($urandom_range(0, text.size() - 1));
					1: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(1, 255));
					default: while (text.size() > 1 && $urandom_range(2) != 0)
						void'(text.pop_back());
				endcase
			end
		end
		// terminator: none, a zero byte, or a zero byte with trailing junk
		case ($urandom_range(9))
			5, 6, 7: text.push_back(CH_NUL);
			8, 9: begin
				text.push_back(CH_NUL);
				repeat ($urandom_range(1, 4))
					text.push_back(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- result sink

	always @(negedge clk) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	// Each result transfer against the oldest prediction, field by field
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected result seconds=%0d invalid=%0b", $time,
					result_if.seconds, result_if.invalid);
				fault_count++;
			end else begin
				want_res = pending_dates.pop_front();
				if (result_if.seconds !== want_res.seconds) begin
					$display("%0t: seconds mismatch: expected %0d, got %0d", $time,
						want_res.seconds, result_if.seconds);
					fault_count++;
				end
				if (result_if.invalid !== want_res.invalid) begin
					$display("%0t: invalid mismatch: expected %0b, got %0b", $time,
						want_res.invalid, result_if.invalid);
					fault_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Calendar extremes, leap day and range limits on every field
	task automatic test_dates_and_ranges();
		send_string("1 JAN 1970");
		send_string("31-dec-2050");
		send_string("29 Feb 2000");
		send_string("29 feb 1999");
		send_string("1 1 70");
		send_string("31 12 100");
		send_string("0 1 1970");
		send_string("32 1 1970");
		send_string("1 13 1970");
		send_string("1 0 1970");
		send_string("1 1 1969");
		send_string("1 1 2051");
		send_string("1 1 0");
	endtask

	// All twelve names in mixed case, plus full, short and odd names
	task automatic test_month_tokens();
		for (int m = 0; m < 12; m++) begin
			put_text("10 ");
			put_word(cal_name[m], 3);
			put_text(" 1990");
			send_text();
		end
		send_string("1 january 1980");
		send_string("1 JA 1980");
		send_string("1 {AN 1980");
		send_string("1 1JA 1980");
	endtask

	// Junk after the terminator, missing tokens, length limit, saturation
	task automatic test_string_edges();
		put_text("2 MAR 1980");
		text.push_back(CH_NUL);
		put_text("zz 9");
		send_text();
		text.push_back(CH_NUL);
		send_text();
		send_string("5");
		send_string("1 JAN");
		send_string("--  7 --  jul   1995 -- x y z");
		// 62 bytes pass, 63 do not
		put_text("1 JAN 1980");
		repeat (52) text.push_back(CH_SPACE);
		send_text();
		put_text("1 JAN 1980");
		repeat (53) text.push_back(CH_SPACE);
		send_text();
		send_string("99999999 1 1970");
		send_string("1 1 99999999");
		send_string("1a JAN 1980");
		send_string("1 JAN 198O");
		put_text("1 ");
		text.push_back(8'hFF);
		text.push_back(8'h80);
		put_text(" 1980");
		send_text();
	endtask

	task automatic test_random_strings(int unsigned n);
		int unsigned start;
		start = sent_chars;
		while (sent_chars - start < n) begin
			build_date_text();
			send_text();
		end
	endtask

	initial begin
		chars_if.valid = 1'b0;
		chars_if.ch = CH_NUL;
		chars_if.last = 1'b0;
		clear_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// slow sender, very slow receiver
		send_idle_pct = 36;
		take_idle_pct = 87;
		test_dates_and_ranges();
		test_month_tokens();
		test_random_strings(250);

		// very slow sender, slow receiver
		send_idle_pct = 87;
		take_idle_pct = 36;
		test_string_edges();
		test_random_strings(250);

		// full rate on both sides
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random_strings(250);

		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
